>>> src/ps2_mouse_packet_cursor_defines.svh
// assertion macros shared by the ps2 mouse packet cursor rtl
// no dependencies; taken in by `include where assertions are written
`ifndef PS2_MOUSE_PACKET_CURSOR_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_DEFINES_SVH

// checked only while out of reset
`define PMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked at every edge, reset included
`define PMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/ps2mpc_pkg.sv
// types and constants of the ps2 mouse packet cursor
// no dependencies; used by scoped names in every module
package ps2mpc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 12;
  localparam int unsigned DeltaW = 9;
  localparam int unsigned CfgIdxW = 2;

  // sync flag position in the first byte of a packet
  localparam int unsigned SyncBit = 3;

  localparam logic [PosW-1:0] CursorStart = 12'd200;
  localparam logic [PosW-1:0] WidthReset  = 12'd1024;
  localparam logic [PosW-1:0] HeightReset = 12'd768;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_reg_e;

  // input stage content handed to the decoder
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } stage_t;

endpackage

>>> src/ps2_mouse_packet_cursor.sv
// top level of the ps2 mouse packet cursor
// depends on ps2mpc_pkg, ps2mpc_in_reg and ps2mpc_decode
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid_i / in_stall_o | data_byte_i
//  out     | out_valid_o / out_stall_i | buttons, overflow flags, deltas, cursor
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte is taken per cycle while in_stall_o is low; a result shows after its third
// byte passes the input register and then the result register
// reset clears the byte position, sets the cursor to 200,200 and the limits
// to 1024 and 768; configuration writes are always ready
// a held result stalls the input only when a packet end is waiting behind it
module ps2_mouse_packet_cursor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ps2mpc_pkg::ByteW-1:0]         data_byte_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ps2mpc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ps2mpc_pkg::PosW-1:0]          cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 left_button_o,
  output logic                                 right_button_o,
  output logic                                 middle_button_o,
  output logic                                 x_overflow_o,
  output logic                                 y_overflow_o,
  output logic signed [ps2mpc_pkg::DeltaW-1:0] delta_x_o,
  output logic signed [ps2mpc_pkg::DeltaW-1:0] delta_y_o,
  output logic [ps2mpc_pkg::PosW-1:0]          cursor_x_o,
  output logic [ps2mpc_pkg::PosW-1:0]          cursor_y_o
);

  ps2mpc_pkg::stage_t stage;
  logic               advance;

  assign cfg_ready_o = 1'b1;

  // input register
  ps2mpc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .stage_o     (stage)
  );

  // packet decode and cursor
  ps2mpc_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .advance_o       (advance),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_button_o   (left_button_o),
    .right_button_o  (right_button_o),
    .middle_button_o (middle_button_o),
    .x_overflow_o    (x_overflow_o),
    .y_overflow_o    (y_overflow_o),
    .delta_x_o       (delta_x_o),
    .delta_y_o       (delta_y_o),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o)
  );

endmodule

>>> src/ps2mpc_in_reg.sv
// input register stage of the ps2 mouse packet cursor
// depends on ps2mpc_pkg
module ps2mpc_in_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ps2mpc_pkg::ByteW-1:0] data_byte_i,
  input  logic                        advance_i,
  output ps2mpc_pkg::stage_t          stage_o
);

  logic                         valid_q, valid_d;
  logic [ps2mpc_pkg::ByteW-1:0] data_q;
  logic                         accept;

  // hold off only when the held byte cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // byte capture on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

>>> src/ps2mpc_decode.sv
// packet assembly, cursor update and result register
// depends on ps2mpc_pkg and ps2_mouse_packet_cursor_defines.svh
`include "ps2_mouse_packet_cursor_defines.svh"
module ps2mpc_decode (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ps2mpc_pkg::stage_t                  stage_i,
  output logic                                advance_o,
  input  logic                                cfg_valid_i,
  input  logic [ps2mpc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ps2mpc_pkg::PosW-1:0]         cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                left_button_o,
  output logic                                right_button_o,
  output logic                                middle_button_o,
  output logic                                x_overflow_o,
  output logic                                y_overflow_o,
  output logic signed [ps2mpc_pkg::DeltaW-1:0] delta_x_o,
  output logic signed [ps2mpc_pkg::DeltaW-1:0] delta_y_o,
  output logic [ps2mpc_pkg::PosW-1:0]         cursor_x_o,
  output logic [ps2mpc_pkg::PosW-1:0]         cursor_y_o
);

  localparam int unsigned SumW = ps2mpc_pkg::PosW + 2;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } pos_e;

  pos_e                              pos_q, pos_d;
  logic [ps2mpc_pkg::ByteW-1:0]      first_q, second_q;
  logic [ps2mpc_pkg::PosW-1:0]       width_q, height_q;
  logic [ps2mpc_pkg::PosW-1:0]       cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  logic                              out_valid_q;
  logic [4:0]                        flags_q;
  logic signed [ps2mpc_pkg::DeltaW-1:0] dx_q, dy_q, dx, dy;
  logic                              out_free, complete, store_first;
  logic signed [SumW-1:0]            sum_x, sum_y;

  // clamp a signed sum to 0..limit
  function automatic logic [ps2mpc_pkg::PosW-1:0] clamp(
    input logic signed [SumW-1:0]       sum,
    input logic [ps2mpc_pkg::PosW-1:0]  limit
  );
    logic [ps2mpc_pkg::PosW-1:0] res;
    if (sum < 0) begin
      res = '0;
    end else if (sum[SumW-2:0] > {1'b0, limit}) begin
      res = limit;
    end else begin
      res = sum[ps2mpc_pkg::PosW-1:0];
    end
    return res;
  endfunction

  // handshake toward the input stage
  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance_o = stage_i.valid && ((pos_q != POS_THIRD) || out_free);
  assign complete  = advance_o && (pos_q == POS_THIRD);

  // deltas from the stored bytes and the incoming third byte
  assign dx = {first_q[4], second_q};
  assign dy = {first_q[5], stage_i.data};

  // y grows downwards, so it moves against delta_y
  assign sum_x = $signed({2'b00, cur_x_q}) + SumW'(dx);
  assign sum_y = $signed({2'b00, cur_y_q}) - SumW'(dy);

  // byte position sequencing; an unused code counts as packet start
  always_comb begin
    pos_d       = pos_q;
    store_first = 1'b0;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    if (advance_o) begin
      case (pos_q)
        POS_SECOND: pos_d = POS_THIRD;
        POS_THIRD: begin
          pos_d   = POS_FIRST;
          cur_x_d = clamp(sum_x, width_q);
          cur_y_d = clamp(sum_y, height_q);
        end
        default: begin
          if (stage_i.data[ps2mpc_pkg::SyncBit]) begin
            pos_d       = POS_SECOND;
            store_first = 1'b1;
          end
        end
      endcase
    end
  end

  // state, configuration and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_FIRST;
      cur_x_q     <= ps2mpc_pkg::CursorStart;
      cur_y_q     <= ps2mpc_pkg::CursorStart;
      width_q     <= ps2mpc_pkg::WidthReset;
      height_q    <= ps2mpc_pkg::HeightReset;
      out_valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ps2mpc_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          ps2mpc_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (complete) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // packet bytes and result payload
  always_ff @(posedge clk_i) begin
    if (store_first) begin
      first_q <= stage_i.data;
    end
    if (advance_o && (pos_q == POS_SECOND)) begin
      second_q <= stage_i.data;
    end
    if (complete) begin
      flags_q <= {first_q[7], first_q[6], first_q[2], first_q[1], first_q[0]};
      dx_q    <= dx;
      dy_q    <= dy;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_button_o   = flags_q[0];
  assign right_button_o  = flags_q[1];
  assign middle_button_o = flags_q[2];
  assign x_overflow_o    = flags_q[3];
  assign y_overflow_o    = flags_q[4];
  assign delta_x_o       = dx_q;
  assign delta_y_o       = dy_q;
  assign cursor_x_o      = cur_x_q;
  assign cursor_y_o      = cur_y_q;

  `PMC_ASSERT(a_pos_legal, clk_i, rst_ni,
    (pos_q == POS_FIRST) || (pos_q == POS_SECOND) || (pos_q == POS_THIRD),
    "byte position reached unused code")
  `PMC_ASSERT(a_result_loaded, clk_i, rst_ni, complete |=> out_valid_q, "packet end gave no result")
  `PMC_ASSERT(a_drop_nosync, clk_i, rst_ni,
    (advance_o && pos_q == POS_FIRST && !stage_i.data[ps2mpc_pkg::SyncBit]) |=> pos_q == POS_FIRST,
    "byte without sync bit started a packet")
  `PMC_ASSERT(a_cursor_x_bound, clk_i, rst_ni, out_valid_q |-> cur_x_q <= width_q,
    "cursor x beyond width limit")

endmodule
